// ----- src/fdm_pkg.sv -----
// Shared types and constants for the floppy drive mechanics block.
package fdm_pkg;

  localparam int COUNT_WIDTH = 24;
  localparam int DIV_WIDTH   = COUNT_WIDTH + 1;
  localparam int DIV_STEPS   = DIV_WIDTH;
  localparam int STEP_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Raw bytes per track are 25 << 7 (5.25-inch), doubled by 8-inch and by
  // double density, so ticks per byte is a shift followed by a divide by 25
  localparam int BASE_SHIFT  = 7;
  localparam int PB_W        = COUNT_WIDTH - BASE_SHIFT;
  localparam int RECIP_SHIFT = PB_W + 5;
  localparam int RECIP_W     = RECIP_SHIFT - 4;
  localparam int PROD_W      = PB_W + RECIP_W;
  localparam longint RECIP_25_L = ((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25;
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(RECIP_25_L);

  localparam logic [COUNT_WIDTH-1:0] INDEX_TICKS   = COUNT_WIDTH'(2000);
  localparam logic [14:0]            CHAR_POS_MAX  = 15'h7FFF;

  localparam logic [CFG_IDX_W-1:0] REG_EIGHT_INCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REV = 2'd3;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_STEP   = 3'd1;
  localparam logic [2:0] CMD_SIDE   = 3'd2;
  localparam logic [2:0] CMD_MOTOR  = 3'd3;
  localparam logic [2:0] CMD_LOAD   = 3'd4;
  localparam logic [2:0] CMD_CHANGE = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP, OP_TICK, OP_STEP, OP_SIDE, OP_MOTOR, OP_LOAD, OP_CHANGE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] cycles;
    logic        direction;
    logic [7:0]  side;
    logic        level;
    logic        disk_present;
    logic        disk_write_protect;
    logic        double_density;
  } item_t;

endpackage

// ----- src/fdm_if.sv -----
// Channel interfaces for command transactions and status results.
interface fdm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] cycles;
  logic        direction;
  logic [7:0]  side;
  logic        level;
  logic        disk_present;
  logic        disk_write_protect;
  logic        double_density;
  modport source (output valid, command, cycles, direction, side, level, disk_present,
                  disk_write_protect, double_density, input ready);
  modport sink (input valid, command, cycles, direction, side, level, disk_present,
                disk_write_protect, double_density, output ready);
endinterface

interface fdm_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  track;
  logic        head;
  logic        track_zero;
  logic        index_pulse;
  logic        write_protected;
  logic        head_loaded;
  logic        motor_on;
  logic [14:0] char_pos;
  modport source (output valid, track, head, track_zero, index_pulse, write_protected,
                  head_loaded, motor_on, char_pos, input ready);
  modport sink (input valid, track, head, track_zero, index_pulse, write_protected,
                head_loaded, motor_on, char_pos, output ready);
endinterface

// ----- src/fdm_front.sv -----
// Front end: accepts command transactions, decodes them and queues them.
module fdm_front import fdm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  fdm_in_if.sink in_ch,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   fill_r;
  item_t            dec;
  logic             push, pop;

  always_comb begin
    dec.cycles             = in_ch.cycles;
    dec.direction          = in_ch.direction;
    dec.side               = in_ch.side;
    dec.level              = in_ch.level;
    dec.disk_present       = in_ch.disk_present;
    dec.disk_write_protect = in_ch.disk_write_protect;
    dec.double_density     = in_ch.double_density;
    case (in_ch.command)
      CMD_TICK:   dec.op = OP_TICK;
      CMD_STEP:   dec.op = OP_STEP;
      CMD_SIDE:   dec.op = OP_SIDE;
      CMD_MOTOR:  dec.op = OP_MOTOR;
      CMD_LOAD:   dec.op = OP_LOAD;
      CMD_CHANGE: dec.op = OP_CHANGE;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = (fill_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= dec;
  end
endmodule

// ----- src/fdm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module fdm_div import fdm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIV_WIDTH-1:0]   dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [DIV_WIDTH-1:0]   quotient,
  output logic [COUNT_WIDTH-1:0] remainder
);
  logic [DIV_WIDTH-1:0]   rem_r, quo_r;
  logic [COUNT_WIDTH-1:0] den_r;
  logic [STEP_CNT_W-1:0]  cnt_r;
  logic                   busy_r, done_r;
  logic [DIV_WIDTH-1:0]   shifted, diff;
  logic                   fits;

  assign shifted   = {rem_r[DIV_WIDTH-2:0], quo_r[DIV_WIDTH-1]};
  assign fits      = shifted >= {1'b0, den_r};
  assign diff      = shifted - {1'b0, den_r};
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff : shifted;
      quo_r <= {quo_r[DIV_WIDTH-2:0], fits};
    end
  end
endmodule

// ----- src/fdm_back.sv -----
// Back end: drive state, configuration registers, sequencer and result register.
module fdm_back import fdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  fdm_out_if.source             out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_MOD, S_PB, S_POS, S_OUT} state_t;

  state_t                 state_r;
  logic                   eight_r;
  logic [1:0]             heads_r;
  logic [7:0]             tracks_r;
  logic [COUNT_WIDTH-1:0] tpr_r;
  logic [6:0]             track_r;
  logic                   hsel_r, index_r, motor_r, load_r, disk_r, prot_r;
  logic [COUNT_WIDTH-1:0] rc_r;
  logic                   dd_r;

  logic                   out_valid_r;
  logic [6:0]             o_track_r;
  logic                   o_head_r, o_tz_r, o_idx_r, o_wp_r, o_load_r, o_motor_r;
  logic [14:0]            o_pos_r;
  logic [DIV_WIDTH-1:0]   pos_q_r;

  logic                   div_start, div_done;
  logic [DIV_WIDTH-1:0]   div_a, quo;
  logic [COUNT_WIDTH-1:0] div_b, rem;
  logic [6:0]             last_track;
  logic [PB_W-1:0]        pb_t;
  logic [PROD_W-1:0]      pb_prod;
  logic [PB_W-5:0]        pb_q;
  logic [COUNT_WIDTH-1:0] per_byte;
  logic                   out_free;
  logic                   tick_mod;

  fdm_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    if (tracks_r == 8'd0)       last_track = 7'd0;
    else if (tracks_r[7])       last_track = 7'd127;
    else                        last_track = tracks_r[6:0] - 7'd1;
    // ticks per byte by reciprocal multiplication
    pb_t     = PB_W'(tpr_r >> (BASE_SHIFT + int'(eight_r) + int'(dd_r)));
    pb_prod  = PROD_W'(pb_t) * PROD_W'(RECIP_25);
    pb_q     = pb_prod[PROD_W-1:RECIP_SHIFT];
    per_byte = (pb_q == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(pb_q);
  end

  assign tick_mod = (q_item.op == OP_TICK) && disk_r && motor_r && (tpr_r != '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // divider operands per sequencer step
  always_comb begin
    div_start = 1'b0;
    div_a     = {1'b0, rc_r};
    div_b     = tpr_r;
    case (state_r)
      S_IDLE: begin
        div_a     = {1'b0, rc_r} + DIV_WIDTH'(q_item.cycles);
        div_start = q_valid && tick_mod;
      end
      S_PB: begin
        div_b     = per_byte;
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eight_r     <= 1'b0;
      heads_r     <= 2'd1;
      tracks_r    <= 8'd40;
      tpr_r       <= COUNT_WIDTH'(400000);
      track_r     <= '0;
      hsel_r      <= 1'b0;
      rc_r        <= '0;
      index_r     <= 1'b0;
      motor_r     <= 1'b0;
      load_r      <= 1'b1;
      disk_r      <= 1'b0;
      prot_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_EIGHT_INCH:    eight_r  <= cfg_data[0];
          REG_HEAD_COUNT:    heads_r  <= cfg_data[1:0];
          REG_TRACK_COUNT:   tracks_r <= cfg_data[7:0];
          REG_TICKS_PER_REV: tpr_r    <= cfg_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            dd_r <= q_item.double_density;
            // tick without spin-up leaves the counter alone
            state_r <= tick_mod ? S_MOD : S_PB;
            case (q_item.op)
              OP_TICK: begin
                if (disk_r && motor_r && tpr_r == '0) begin
                  rc_r    <= '0;
                  index_r <= 1'b1;
                end
              end
              OP_STEP: begin
                if (q_item.direction) begin
                  if (track_r < last_track) track_r <= track_r + 7'd1;
                end else if (track_r != 7'd0) begin
                  track_r <= track_r - 7'd1;
                end
              end
              OP_SIDE:   hsel_r <= heads_r[1] ? q_item.side[0] : 1'b0;
              OP_MOTOR:  if (!eight_r) motor_r <= q_item.level;
              OP_LOAD:   if (eight_r)  load_r  <= q_item.level;
              OP_CHANGE: begin
                disk_r <= q_item.disk_present;
                prot_r <= q_item.disk_present & q_item.disk_write_protect;
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          if (div_done) begin
            rc_r    <= rem;
            index_r <= rem < INDEX_TICKS;
            state_r <= S_PB;
          end
        end
        S_PB: begin
          state_r <= S_POS;
        end
        S_POS: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_POS && div_done) pos_q_r <= quo;
    if (state_r == S_OUT && out_free) begin
      o_track_r <= track_r;
      o_head_r  <= hsel_r;
      o_tz_r    <= (track_r == 7'd0);
      o_idx_r   <= index_r;
      o_wp_r    <= prot_r;
      o_load_r  <= load_r;
      o_motor_r <= motor_r;
      o_pos_r   <= (pos_q_r > DIV_WIDTH'(CHAR_POS_MAX)) ? CHAR_POS_MAX : pos_q_r[14:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.track           = o_track_r;
  assign out_ch.head            = o_head_r;
  assign out_ch.track_zero      = o_tz_r;
  assign out_ch.index_pulse     = o_idx_r;
  assign out_ch.write_protected = o_wp_r;
  assign out_ch.head_loaded     = o_load_r;
  assign out_ch.motor_on        = o_motor_r;
  assign out_ch.char_pos        = o_pos_r;
endmodule

// ----- src/floppy_drive_mechanics.sv -----
// A counting tick runs two divides (modulo, then position) on the shared 25-step
// divider, any other command one; each result then waits until the output is free.
// The back end finishes one item before it takes the next from the queue, and a
// two-entry queue takes new transactions while the back end works.
// Synchronous active-low reset restores drive state; the drive starts as 5.25-inch.
module floppy_drive_mechanics import fdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fdm_in_if.sink                in_ch,
  fdm_out_if.source             out_ch
);
  logic  q_valid, q_pop;
  item_t q_item;

  fdm_front u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_item, .q_pop
  );

  fdm_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_item, .q_pop, .out_ch
  );
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the floppy drive mechanics block.
module testbench import fdm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0]  track;
    logic        head;
    logic        track_zero;
    logic        index_pulse;
    logic        write_protected;
    logic        head_loaded;
    logic        motor_on;
    logic [14:0] char_pos;
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] cycles;
    logic        direction;
    logic [7:0]  side;
    logic        level;
    logic        disk_present;
    logic        disk_write_protect;
    logic        double_density;
  } cmd_t;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    status_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fdm_in_if  in_ch ();
  fdm_out_if out_ch ();

  floppy_drive_mechanics u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Drive model state and configuration
  logic [0:0]  m_eight;
  logic [1:0]  m_heads;
  logic [7:0]  m_tracks;
  logic [23:0] m_rev;
  logic [6:0]  d_track;
  logic        d_side;
  logic [23:0] d_rot;
  logic        d_index, d_motor, d_load, d_disk, d_wp;

  status_t status_q[$];
  int errors = 0;
  int results_seen = 0;
  int cmds_sent = 0;
  bit hold_off = 0;
  bit calm = 0;

  function automatic status_t drive_step(cmd_t c);
    status_t s;
    int unsigned last, heads;
    longint unsigned sum, bytes, per_byte, pos;
    last = (m_tracks == 0) ? 0 : (m_tracks > 128) ? 127 : m_tracks - 1;
    case (c.command)
      CMD_TICK: if (d_disk && d_motor) begin
        sum = longint'(d_rot) + c.cycles;
        d_rot = (m_rev == 0) ? 24'd0 : 24'(sum % m_rev);
        d_index = d_rot < INDEX_TICKS;
      end
      CMD_STEP: if (c.direction) begin
        if (d_track < last) d_track++;
      end else if (d_track > 0) begin
        d_track--;
      end
      CMD_SIDE: begin
        heads = (m_heads == 0) ? 1 : (m_heads > 2) ? 2 : m_heads;
        d_side = (c.side % heads) != 0;
      end
      CMD_MOTOR: if (!m_eight) d_motor = c.level;
      CMD_LOAD: if (m_eight) d_load = c.level;
      CMD_CHANGE: begin
        d_disk = c.disk_present;
        d_wp = c.disk_present & c.disk_write_protect;
      end
      default: ;
    endcase
    bytes = m_eight ? 6400 : 3200;
    if (c.double_density) bytes *= 2;
    per_byte = m_rev / bytes;
    if (per_byte == 0) per_byte = 1;
    pos = d_rot / per_byte;
    if (pos > 32767) pos = 32767;
    s.track = d_track;
    s.head = d_side;
    s.track_zero = d_track == 0;
    s.index_pulse = d_index;
    s.write_protected = d_wp;
    s.head_loaded = d_load;
    s.motor_on = d_motor;
    s.char_pos = 15'(pos);
    return s;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_EIGHT_INCH:    m_eight = val[0];
      REG_HEAD_COUNT:    m_heads = val[1:0];
      REG_TRACK_COUNT:   m_tracks = val[7:0];
      REG_TICKS_PER_REV: m_rev = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // Offer one command, with a random gap first unless calm; hold valid until accepted
  task automatic send_cmd(cmd_t c, bit typed, status_t want);
    status_t got;
    if (!calm) while ($urandom_range(99) < 26) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.command, in_ch.cycles, in_ch.direction, in_ch.side, in_ch.level,
     in_ch.disk_present, in_ch.disk_write_protect, in_ch.double_density} <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = drive_step(c);
    if (typed && got !== want) begin
      errors++;
      if (errors <= 10) $display("typed row %0d: expected %h model %h", cmds_sent, want, got);
    end
    status_q.push_back(got);
    cmds_sent++;
    @(negedge clk);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = cmd_t'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: c.command = CMD_TICK;
      4, 5: c.command = CMD_STEP;
      6: c.command = CMD_SIDE;
      7: c.command = $urandom_range(1) ? CMD_MOTOR : CMD_LOAD;
      8: c.command = $urandom_range(3) ? CMD_CHANGE : 3'($urandom_range(7));
      default: c.command = 3'($urandom_range(7));
    endcase
    if (c.command == CMD_CHANGE && $urandom_range(3) != 0) c.disk_present = 1;
    return c;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [15:0] cyc = 0, logic dir = 0,
                              logic [7:0] sd = 0, logic lv = 0, logic pr = 0,
                              logic wp = 0, logic dd = 0);
    return {op, cyc, dir, sd, lv, pr, wp, dd};
  endfunction

  // Result checker: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.track, out_ch.head, out_ch.track_zero, out_ch.index_pulse,
             out_ch.write_protected, out_ch.head_loaded, out_ch.motor_on, out_ch.char_pos};
      results_seen++;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected status %h", got);
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("status %0d: expected trk %0d hd %0d t0 %0d idx %0d wp %0d ld %0d mo %0d cp %0d, got trk %0d hd %0d t0 %0d idx %0d wp %0d ld %0d mo %0d cp %0d",
              results_seen, want.track, want.head, want.track_zero, want.index_pulse,
              want.write_protected, want.head_loaded, want.motor_on, want.char_pos,
              got.track, got.head, got.track_zero, got.index_pulse, got.write_protected,
              got.head_loaded, got.motor_on, got.char_pos);
        end
      end
    end
  end

  // Receiver: random stalls, a long hold-off on request
  initial begin
    int hold;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 0;
        for (hold = 0; hold < 600; hold++) @(negedge clk);
        hold_off = 0;
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  initial begin
    row_t rows[$];
    status_t z;
    status_t w;
    int phase, k;
    z = '0;
    rst_n = 0;
    cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 0;
    {in_ch.command, in_ch.cycles, in_ch.direction, in_ch.side, in_ch.level,
     in_ch.disk_present, in_ch.disk_write_protect, in_ch.double_density} = '0;
    m_eight = 0; m_heads = 1; m_tracks = 40; m_rev = 400000;
    d_track = 0; d_side = 0; d_rot = 0; d_index = 0;
    d_motor = 0; d_load = 1; d_disk = 0; d_wp = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed table; after reset the state is read off at a glance
    w = z; w.track_zero = 1; w.head_loaded = 1;
    rows.push_back('{mk(CMD_TICK, 16'hFFFF), 1, w});
    rows.push_back('{mk(3'd6), 1, w});
    rows.push_back('{mk(3'd7, 16'hFFFF, 1, 8'hFF, 1, 1, 1, 1), 1, w});
    rows.push_back('{mk(CMD_STEP, 0, 0), 1, w});
    rows.push_back('{mk(CMD_SIDE, 0, 0, 8'hFF), 1, w});
    w.motor_on = 1;
    rows.push_back('{mk(CMD_MOTOR, 0, 0, 0, 1), 1, w});
    rows.push_back('{mk(CMD_LOAD, 0, 0, 0, 0), 1, w});
    w.write_protected = 1;
    rows.push_back('{mk(CMD_CHANGE, 0, 0, 0, 0, 1, 1), 1, w});
    rows.push_back('{mk(CMD_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 1), 0, z});
    rows.push_back('{mk(CMD_TICK, 16'h0000), 0, z});
    rows.push_back('{mk(CMD_STEP, 0, 1), 0, z});
    rows.push_back('{mk(CMD_STEP, 0, 1), 0, z});
    rows.push_back('{mk(CMD_CHANGE, 0, 0, 0, 0, 0, 1), 0, z});
    rows.push_back('{mk(CMD_TICK, 16'h1234), 0, z});
    rows.push_back('{mk(CMD_CHANGE, 0, 0, 0, 0, 1, 0), 0, z});
    for (k = 0; k < 8; k++) rows.push_back('{mk(CMD_TICK, 16'hFFFF, 0, 0, 0, 0, 0, k[0]), 0, z});
    rows.push_back('{mk(CMD_STEP, 0, 0), 0, z});
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
    drain();

    // Random phases under several configurations, extremes included
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_HEAD_COUNT, 2); write_reg(REG_TRACK_COUNT, 3);
                 write_reg(REG_TICKS_PER_REV, 12800); end
        1: begin write_reg(REG_EIGHT_INCH, 1); write_reg(REG_TICKS_PER_REV, 24'hFFFFFF);
                 write_reg(REG_TRACK_COUNT, 128); end
        2: begin write_reg(REG_HEAD_COUNT, 0); write_reg(REG_TRACK_COUNT, 0);
                 write_reg(REG_TICKS_PER_REV, 0); end
        3: begin write_reg(REG_EIGHT_INCH, 0); write_reg(REG_HEAD_COUNT, 3);
                 write_reg(REG_TRACK_COUNT, 255); write_reg(REG_TICKS_PER_REV, 5000); end
        4: begin write_reg(REG_TRACK_COUNT, 2); write_reg(REG_TICKS_PER_REV, 24'hFFFFFF); end
        5: begin write_reg(REG_EIGHT_INCH, 1); write_reg(REG_HEAD_COUNT, 1);
                 write_reg(REG_TRACK_COUNT, 1); write_reg(REG_TICKS_PER_REV, 70000); end
        6: begin write_reg(REG_EIGHT_INCH, 0); write_reg(REG_TRACK_COUNT, 80);
                 write_reg(REG_TICKS_PER_REV, 400000); calm = 1; end
        default: begin write_reg(REG_HEAD_COUNT, 2); write_reg(REG_TICKS_PER_REV, 66666);
                 calm = 0; hold_off = 1; end
      endcase
      for (k = 0; k < 80; k++) send_cmd(rand_cmd(), 0, z);
      drain();
    end

    $display("Ran %0d command transactions over eight drive settings, %0d statuses checked.",
             cmds_sent, results_seen);
    if (errors == 0 && status_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/fdm_pkg.sv
src/fdm_if.sv
src/fdm_front.sv
src/fdm_div.sv
src/fdm_back.sv
src/floppy_drive_mechanics.sv
tb/testbench.sv
